[hdl/chp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package chp_pkg;

   // Largest digest length a profile may use
   localparam int DIGEST_MAX = 64;

   // Field widths
   localparam int DIGEST_W    = 7;
   localparam int OFFSET_W    = 32;
   localparam int TOTAL_W     = 33;
   localparam int CERT_SIZE_W = 32;
   localparam int TAG_LEN_W   = 16;

   // Result stream packing
   localparam int RSP_TDATA_W = 128;
   localparam int RSP_TUSER_W = 3;

   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

   // Parser phases, also the field kind of a byte
   localparam logic [2:0] PH_VER    = 3'd0;
   localparam logic [2:0] PH_FLAGS  = 3'd1;
   localparam logic [2:0] PH_DIGEST = 3'd2;
   localparam logic [2:0] PH_CLEN   = 3'd3;
   localparam logic [2:0] PH_CERT   = 3'd4;
   localparam logic [2:0] PH_TLEN   = 3'd5;
   localparam logic [2:0] PH_TAG    = 3'd6;
   localparam logic [2:0] PH_TRAIL  = 3'd7;

   // Status codes
   localparam logic [3:0] ST_PENDING = 4'd0;
   localparam logic [3:0] ST_OK      = 4'd1;
   localparam logic [3:0] ST_PROFILE = 4'd2;
   localparam logic [3:0] ST_SHORT   = 4'd3;
   localparam logic [3:0] ST_VERSION = 4'd4;
   localparam logic [3:0] ST_FLAGS   = 4'd5;
   localparam logic [3:0] ST_CERTCUT = 4'd6;
   localparam logic [3:0] ST_TLENCUT = 4'd7;
   localparam logic [3:0] ST_TAGCUT  = 4'd8;

   // Held-back header errors
   localparam logic [1:0] PE_NONE    = 2'd0;
   localparam logic [1:0] PE_VERSION = 2'd1;
   localparam logic [1:0] PE_FLAGS   = 2'd2;

   // Control register indexes
   localparam logic [1:0] CSR_DIGEST_BYTES     = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_VERSION = 2'd1;
   localparam logic [1:0] CSR_TAG_FLAG_MASK    = 2'd2;

   // One tagged output byte
   typedef struct packed {
      logic                   tag_present;
      logic [TAG_LEN_W-1:0]   tag_length;
      logic [CERT_SIZE_W-1:0] cert_length;
      logic [TOTAL_W-1:0]     consumed_count;
      logic [3:0]             status;
      logic [OFFSET_W-1:0]    field_offset;
      logic [2:0]             field_kind;
      logic [7:0]             byte_out;
   } result_type;

endpackage

`default_nettype wire

[hdl/chunk_header_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// Chunk header parser. Bytes of a buffer enter on the req stream (tlast on the
// final byte) and leave on the rsp stream one for one, each tagged with its
// field kind (tuser) and its offset in that field, along with the status known
// so far, the decoded cert and tag lengths and, once the header is complete
// and good, the header length. The parser takes one byte per clock while the
// skid entry is empty; the per-byte step is a single pass through the field
// walker (a 32-bit offset counter with its length compare). Each result is
// registered in a two-entry output stage, which keeps the input open for one
// more byte while a result waits. Errors hold until the buffer ends; all
// parse state returns to reset after the last byte, the control registers are kept.

module chunk_header_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input stream
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  wire logic                           req_tlast,
   // result stream
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [7:0] byte_out, [39:8] field_offset, [43:40] status, [76:44] consumed_count,
   // [108:77] cert_length, [124:109] tag_length, [125] tag_present, [127:126] zero
   output      logic [chp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output      logic [chp_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // [2:0] field_kind
   // control registers
   input  wire logic                           csr_we,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [7:0]                     csr_wdata
);
   import chp_pkg::*;

   // Control registers
   logic [DIGEST_W-1:0]    digest_bytes_ff;
   logic [7:0]             expected_version_ff;
   logic [7:0]             tag_flag_mask_ff;

   // Parse state
   logic [2:0]             phase_ff,     phase_in;
   logic [OFFSET_W-1:0]    fcount_ff,    fcount_in;
   logic [CERT_SIZE_W-1:0] cert_size_ff, cert_size_in;
   logic [TAG_LEN_W-1:0]   tag_len_ff,   tag_len_in;
   logic [7:0]             flags_ff,     flags_in;
   logic [1:0]             perr_ff,      perr_in;
   logic [TOTAL_W-1:0]     total_ff,     total_in;
   logic [3:0]             status_ff,    status_in;
   logic [TOTAL_W-1:0]     hdr_len_ff,   hdr_len_in;

   // Output stage
   result_type             out_ff,       skid_ff;
   logic                   out_valid_ff, skid_valid_ff;
   result_type             result;

   logic                   accept;
   logic                   bad_profile;
   logic [DIGEST_W-1:0]    dlen;
   logic [OFFSET_W-1:0]    fcount_inc;
   logic                   tag_flag;
   logic                   out_free;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign bad_profile = (digest_bytes_ff == '0) ||
                        (digest_bytes_ff > DIGEST_W'(DIGEST_MAX));
   assign dlen        = bad_profile ? '0 : digest_bytes_ff;
   assign fcount_inc  = fcount_ff + OFFSET_W'(1);
   assign tag_flag    = (flags_ff & tag_flag_mask_ff) != 8'h00;

   // Field walk for one byte
   always_comb begin
      phase_in     = phase_ff;
      fcount_in    = fcount_ff;
      cert_size_in = cert_size_ff;
      tag_len_in   = tag_len_ff;
      flags_in     = flags_ff;
      perr_in      = perr_ff;
      status_in    = status_ff;
      hdr_len_in   = hdr_len_ff;
      total_in     = (total_ff == TOTAL_MAX) ? total_ff : total_ff + TOTAL_W'(1);

      if (bad_profile && status_in == ST_PENDING) begin
         status_in = ST_PROFILE;
      end

      unique case (phase_ff)
         PH_VER: begin
            if (req_tdata != expected_version_ff && perr_ff == PE_NONE) begin
               perr_in = PE_VERSION;
            end
            phase_in  = PH_FLAGS;
            fcount_in = '0;
         end
         PH_FLAGS: begin
            flags_in = req_tdata;
            if ((req_tdata & ~tag_flag_mask_ff) != 8'h00 && perr_ff == PE_NONE) begin
               perr_in = PE_FLAGS;
            end
            phase_in  = (dlen != '0) ? PH_DIGEST : PH_CLEN;
            fcount_in = '0;
         end
         PH_DIGEST: begin
            fcount_in = fcount_inc;
            if (fcount_inc >= OFFSET_W'(dlen)) begin
               phase_in  = PH_CLEN;
               fcount_in = '0;
            end
         end
         PH_CLEN: begin
            cert_size_in = {cert_size_ff[CERT_SIZE_W-9:0], req_tdata};
            fcount_in    = fcount_inc;
            if (fcount_inc >= OFFSET_W'(4)) begin
               // minimum length seen: release held-back errors
               if (status_in == ST_PENDING) begin
                  if (perr_ff == PE_VERSION) begin
                     status_in = ST_VERSION;
                  end else if (perr_ff == PE_FLAGS) begin
                     status_in = ST_FLAGS;
                  end
               end
               fcount_in = '0;
               if (cert_size_in != '0) begin
                  phase_in = PH_CERT;
               end else if (tag_flag) begin
                  phase_in = PH_TLEN;
               end else begin
                  phase_in   = PH_TRAIL;
                  hdr_len_in = total_in;
                  if (status_in == ST_PENDING) status_in = ST_OK;
               end
            end
         end
         PH_CERT: begin
            fcount_in = fcount_inc;
            if (fcount_inc >= cert_size_ff) begin
               fcount_in = '0;
               if (tag_flag) begin
                  phase_in = PH_TLEN;
               end else begin
                  phase_in   = PH_TRAIL;
                  hdr_len_in = total_in;
                  if (status_in == ST_PENDING) status_in = ST_OK;
               end
            end
         end
         PH_TLEN: begin
            tag_len_in = {tag_len_ff[TAG_LEN_W-9:0], req_tdata};
            fcount_in  = fcount_inc;
            if (fcount_inc >= OFFSET_W'(2)) begin
               fcount_in = '0;
               if (tag_len_in == '0) begin
                  if (status_in == ST_PENDING) status_in = ST_TAGCUT;
                  phase_in = PH_TRAIL;
               end else begin
                  phase_in = PH_TAG;
               end
            end
         end
         PH_TAG: begin
            fcount_in = fcount_inc;
            if (fcount_inc >= OFFSET_W'(tag_len_ff)) begin
               phase_in   = PH_TRAIL;
               fcount_in  = '0;
               hdr_len_in = total_in;
               if (status_in == ST_PENDING) status_in = ST_OK;
            end
         end
         default: begin
            // trailing bytes, offset saturates
            if (fcount_ff != OFFSET_MAX) fcount_in = fcount_inc;
         end
      endcase

      // buffer ends inside the header
      if (req_tlast && status_in == ST_PENDING) begin
         if (phase_in <= PH_CLEN) begin
            status_in = ST_SHORT;
         end else if (phase_in == PH_CERT) begin
            status_in = ST_CERTCUT;
         end else if (phase_in == PH_TLEN) begin
            status_in = ST_TLENCUT;
         end else if (phase_in == PH_TAG) begin
            status_in = ST_TAGCUT;
         end
      end
   end

   // Result fields
   always_comb begin
      result.byte_out       = req_tdata;
      result.field_kind     = phase_ff;
      result.field_offset   = fcount_ff;
      result.status         = status_in;
      result.consumed_count = (status_in == ST_OK) ? hdr_len_in : '0;
      result.cert_length    = (phase_in >= PH_CERT) ? cert_size_in : '0;
      result.tag_length     = (phase_in >= PH_TAG) ? tag_len_in : '0;
      result.tag_present    = (phase_ff >= PH_DIGEST) &&
                              ((flags_in & tag_flag_mask_ff) != 8'h00);
   end

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         digest_bytes_ff     <= DIGEST_W'(32);
         expected_version_ff <= 8'd1;
         tag_flag_mask_ff    <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIGEST_BYTES:     digest_bytes_ff     <= csr_wdata[DIGEST_W-1:0];
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata;
            CSR_TAG_FLAG_MASK:    tag_flag_mask_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Parse state update, cleared after the last byte of a buffer
   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         phase_ff     <= PH_VER;
         fcount_ff    <= '0;
         cert_size_ff <= '0;
         tag_len_ff   <= '0;
         flags_ff     <= '0;
         perr_ff      <= PE_NONE;
         total_ff     <= '0;
         status_ff    <= ST_PENDING;
         hdr_len_ff   <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         fcount_ff    <= fcount_in;
         cert_size_ff <= cert_size_in;
         tag_len_ff   <= tag_len_in;
         flags_ff     <= flags_in;
         perr_ff      <= perr_in;
         total_ff     <= total_in;
         status_ff    <= status_in;
         hdr_len_ff   <= hdr_len_in;
      end
   end

   // Output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.field_kind;
   assign rsp_tdata  = {2'b00,
                        out_ff.tag_present,
                        out_ff.tag_length,
                        out_ff.cert_length,
                        out_ff.consumed_count,
                        out_ff.status,
                        out_ff.field_offset,
                        out_ff.byte_out};

endmodule

`default_nettype wire
